### hdl/vrp_pkg.sv
package vrp_pkg;

  localparam int COORD_W   = 32;
  localparam int COEF_W    = 16;
  localparam int SCALE_W   = 24;
  localparam int PROD_W    = 48;
  localparam int NUM_W     = 56;
  localparam int DIV_STEPS = NUM_W;
  localparam int FRONT     = 8;
  localparam int CAM_OFFSET = 10;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FIRST_COS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_SIN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_COS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_SIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_COS  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_SIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PROJ_SCALE = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = 16'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_M_ONE = -16'sd16384;

  // Clamp a raw coefficient to plus or minus one in Q1.14
  function automatic logic signed [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] raw);
    logic signed [COEF_W-1:0] v;
    v = $signed(raw);
    if (v > COEF_ONE) return COEF_ONE;
    if (v < COEF_M_ONE) return COEF_M_ONE;
    return v;
  endfunction

  // Combine two products, round half up to Q16.16 and saturate
  function automatic logic signed [COORD_W-1:0] rot_sum(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     sub
  );
    logic signed [PROD_W:0]    s;
    logic signed [PROD_W-14:0] r;
    s = sub ? (PROD_W+1)'(a) - (PROD_W+1)'(b) : (PROD_W+1)'(a) + (PROD_W+1)'(b);
    s = s + (PROD_W+1)'(8192);
    r = s[PROD_W:14];
    if (r > (PROD_W-13)'(signed'(33'sh0_7fff_ffff))) return 32'sh7fff_ffff;
    if (r < (PROD_W-13)'(signed'(-33'sh0_8000_0000))) return 32'sh8000_0000;
    return r[COORD_W-1:0];
  endfunction

endpackage

### hdl/vrp_div.sv
module vrp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vrp_pkg::NUM_W-1:0]   num,
  input  logic [vrp_pkg::COORD_W-1:0] den,
  input  logic                        neg,
  output logic [vrp_pkg::COORD_W-1:0] quo
);
  import vrp_pkg::*;

  logic [COORD_W-1:0] rem_r [DIV_STEPS];
  logic [NUM_W-1:0]   nq_r  [DIV_STEPS];
  logic [COORD_W-1:0] den_r [DIV_STEPS];
  logic               neg_r [DIV_STEPS];

  // One restoring step per stage: shift in a dividend bit, try subtract
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [COORD_W-1:0] rem_in;
    logic [NUM_W-1:0]   nq_in;
    logic [COORD_W-1:0] den_in;
    logic               neg_in;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               qbit;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign qbit  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= qbit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        nq_r[i]  <= {nq_in[NUM_W-2:0], qbit};
        den_r[i] <= den_in;
        neg_r[i] <= neg_in;
      end
    end
  end

  // Apply sign and saturate the magnitude quotient to 32 bits
  logic [NUM_W-1:0] q_mag;
  assign q_mag = nq_r[DIV_STEPS-1];

  always_comb begin
    if (neg_r[DIV_STEPS-1]) begin
      if (q_mag > NUM_W'(64'h8000_0000)) quo = 32'h8000_0000;
      else                              quo = 32'(-q_mag);
    end else begin
      if (q_mag > NUM_W'(64'h7fff_ffff)) quo = 32'h7fff_ffff;
      else                              quo = q_mag[COORD_W-1:0];
    end
  end

endmodule

### hdl/vertex_rotate_project_core.sv
// Rotates each Q16.16 vertex about z, y and x with the coefficient registers,
// offsets depth by the camera distance, scales x and y by proj_scale and
// divides both by w, saturating to Q16.16; w of zero gives zero outputs and
// sets out_depth_zero. One vertex is taken per clock while the output is
// not stalled. Each vertex passes the three rotations, the depth offset and
// scale products, the sign split, a one-bit-per-stage restoring divider and
// an output register. A stalled output freezes the whole pipeline.
// Configuration writes must be made while no vertex is in flight.
module vertex_rotate_project_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_x,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_y,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vrp_pkg::COORD_W-1:0]  out_x,
  output logic signed [vrp_pkg::COORD_W-1:0]  out_y,
  output logic                                out_depth_zero,
  input  logic                                cfg_we,
  input  logic [vrp_pkg::REG_IDX_W-1:0]       cfg_idx,
  input  logic [vrp_pkg::SCALE_W-1:0]         cfg_data
);
  import vrp_pkg::*;

  // Configuration registers, coefficients held already clamped
  logic signed [COEF_W-1:0] c1_r, s1_r, c2_r, s2_r, c3_r, s3_r;
  logic [SCALE_W-1:0]       scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= COEF_ONE;
      s1_r    <= '0;
      c2_r    <= COEF_ONE;
      s2_r    <= '0;
      c3_r    <= COEF_ONE;
      s3_r    <= '0;
      scale_r <= SCALE_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIRST_COS:  c1_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_FIRST_SIN:  s1_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_SECOND_COS: c2_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_SECOND_SIN: s2_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_THIRD_COS:  c3_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_THIRD_SIN:  s3_r    <= clamp_coef(cfg_data[COEF_W-1:0]);
        REG_PROJ_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a result waits stalled
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic [FRONT-1:0]     fv_r;
  logic [DIV_STEPS-1:0] dv_r;
  logic [DIV_STEPS-1:0] dz_r;

  // Rotation and projection front end
  logic signed [PROD_W-1:0]  p1a_r, p1b_r, p1c_r, p1d_r, p1z_r;
  logic signed [COORD_W-1:0] x2_r, y2_r, z2_r;
  logic signed [PROD_W-1:0]  p3a_r, p3b_r, p3c_r, p3d_r, p3y_r;
  logic signed [COORD_W-1:0] x4_r, y4_r, z4_r;
  logic signed [PROD_W-1:0]  p5a_r, p5b_r, p5c_r, p5d_r, p5x_r;
  logic signed [COORD_W-1:0] x6_r, y6_r, z6_r;
  logic signed [NUM_W-1:0]   nx7_r, ny7_r;
  logic signed [COORD_W-1:0] w7_r;
  logic [NUM_W-1:0]          mx8_r, my8_r;
  logic [COORD_W-1:0]        aw8_r;
  logic                      nx8_r, ny8_r, z8_r;

  logic signed [COORD_W:0]   w_sum;
  logic signed [COORD_W-1:0] w_sat;
  assign w_sum = (COORD_W+1)'(z6_r) + (COORD_W+1)'(CAM_OFFSET <<< 16);
  always_comb begin
    if (w_sum > (COORD_W+1)'(signed'(33'sh0_7fff_ffff)))       w_sat = 32'sh7fff_ffff;
    else if (w_sum < (COORD_W+1)'(signed'(-33'sh0_8000_0000))) w_sat = 32'sh8000_0000;
    else                                                       w_sat = w_sum[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // z rotation
      p1a_r <= in_x * c1_r;
      p1b_r <= in_y * s1_r;
      p1c_r <= in_x * s1_r;
      p1d_r <= in_y * c1_r;
      p1z_r <= PROD_W'(in_z);
      x2_r  <= rot_sum(p1a_r, p1b_r, 1'b1);
      y2_r  <= rot_sum(p1c_r, p1d_r, 1'b0);
      z2_r  <= p1z_r[COORD_W-1:0];
      // y rotation
      p3a_r <= x2_r * c2_r;
      p3b_r <= z2_r * s2_r;
      p3c_r <= z2_r * c2_r;
      p3d_r <= x2_r * s2_r;
      p3y_r <= PROD_W'(y2_r);
      x4_r  <= rot_sum(p3a_r, p3b_r, 1'b0);
      z4_r  <= rot_sum(p3c_r, p3d_r, 1'b1);
      y4_r  <= p3y_r[COORD_W-1:0];
      // x rotation
      p5a_r <= y4_r * c3_r;
      p5b_r <= z4_r * s3_r;
      p5c_r <= y4_r * s3_r;
      p5d_r <= z4_r * c3_r;
      p5x_r <= PROD_W'(x4_r);
      y6_r  <= rot_sum(p5a_r, p5b_r, 1'b1);
      z6_r  <= rot_sum(p5c_r, p5d_r, 1'b0);
      x6_r  <= p5x_r[COORD_W-1:0];
      // depth offset and scale products
      nx7_r <= x6_r * $signed({1'b0, scale_r});
      ny7_r <= y6_r * $signed({1'b0, scale_r});
      w7_r  <= w_sat;
      // split signs for the magnitude divider
      mx8_r <= nx7_r[NUM_W-1] ? NUM_W'(-nx7_r) : NUM_W'(nx7_r);
      my8_r <= ny7_r[NUM_W-1] ? NUM_W'(-ny7_r) : NUM_W'(ny7_r);
      aw8_r <= w7_r[COORD_W-1] ? COORD_W'(-w7_r) : COORD_W'(w7_r);
      nx8_r <= nx7_r[NUM_W-1] ^ w7_r[COORD_W-1];
      ny8_r <= ny7_r[NUM_W-1] ^ w7_r[COORD_W-1];
      z8_r  <= (w7_r == '0);
    end
  end

  logic [COORD_W-1:0] qx, qy;

  vrp_div u_div_x (
    .clk (clk), .en (en), .num (mx8_r), .den (aw8_r), .neg (nx8_r), .quo (qx)
  );

  vrp_div u_div_y (
    .clk (clk), .en (en), .num (my8_r), .den (aw8_r), .neg (ny8_r), .quo (qy)
  );

  // Advance valid bits and the zero-depth flag alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r        <= {fv_r[FRONT-2:0], in_valid};
      dv_r        <= {dv_r[DIV_STEPS-2:0], fv_r[FRONT-1]};
      out_valid_r <= dv_r[DIV_STEPS-1];
    end
  end

  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_dz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r     <= {dz_r[DIV_STEPS-2:0], z8_r};
      out_dz_r <= dz_r[DIV_STEPS-1];
      out_x_r  <= dz_r[DIV_STEPS-1] ? '0 : $signed(qx);
      out_y_r  <= dz_r[DIV_STEPS-1] ? '0 : $signed(qy);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_depth_zero = out_dz_r;

endmodule
